// ===== rtl/dp_link_training_sequencer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef DP_LINK_TRAINING_SEQUENCER_ASSERT_SVH
`define DP_LINK_TRAINING_SEQUENCER_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define DPLT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dp link training assertion failed");

// Clocked assertion that also holds across reset.
`define DPLT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dp link training assertion failed");

`endif

// ===== rtl/dplt_pkg.sv =====
package dplt_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CR   = 2'd1,
    PH_EQ   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_PASS     = 2'd1,
    ST_FAIL     = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  localparam logic [1:0] PAT_OFF = 2'd0;
  localparam logic [1:0] PAT_1   = 2'd1;
  localparam logic [1:0] PAT_2   = 2'd2;
  localparam logic [1:0] PAT_3   = 2'd3;

  // Register byte addresses
  localparam logic [3:0] REG_LANE_MODE = 4'h0;
  localparam logic [3:0] REG_DRIVE_TBL = 4'h4;
  localparam logic [3:0] REG_PAT3_EN   = 4'h8;

  localparam logic [1:0] LANE_MODE_1 = 2'd0;
  localparam logic [1:0] LANE_MODE_2 = 2'd1;

  localparam logic [2:0] CR_BITS = 3'b001;
  localparam logic [2:0] EQ_BITS = 3'b111;

  localparam logic [2:0] REPEAT_LIMIT = 3'd4;
  localparam logic [2:0] EQ_TRY_LIMIT = 3'd5;

  localparam logic [1:0] SWING_LIMIT [2] = '{2'd3, 2'd2};
  localparam logic [1:0] EMPH_LIMIT  [2] = '{2'd3, 2'd3};
  // Swing clamp, indexed {drive_table, emphasis}
  localparam logic [1:0] SWING_CLAMP [8] = '{
    2'd3, 2'd2, 2'd1, 2'd0, 2'd2, 2'd2, 2'd1, 2'd0
  };

  // Drive codes, indexed {drive_table, swing, emphasis}; {valid, code}
  localparam logic [4:0] DRIVE_CODES [32] = '{
    5'h10, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15, 5'h16, 5'h00,
    5'h17, 5'h18, 5'h00, 5'h00, 5'h19, 5'h00, 5'h00, 5'h00,
    5'h10, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15, 5'h16, 5'h00,
    5'h17, 5'h18, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00
  };

  typedef struct packed {
    logic [1:0] swing;
    logic [1:0] emph;
    logic       swing_max;
    logic       emph_max;
  } drive_t;

endpackage

// ===== rtl/dp_link_training_sequencer.sv =====
// Channel   | Dir | Payload                                    | Handshake
// in_*      | in  | tuser command, tdata lane/adjust/align     | tvalid/tready
// out_*     | out | tdata status, pattern, drive, drive code   | tvalid/tready
// cfg_*     | in  | lane_mode, drive_table, pattern3_enable    | APB, pready high
//
// One item per cycle sustained while the result is taken; each item passes through
// an input register, one pass of lane compares, lane max and table lookups,
// then the result register. Training state updates as an item moves to the result.
// Reset (rst_n, synchronous) clears state and both stage valids and loads config defaults.
// A stalled result holds; the input stage takes a new item whenever it drains.
module dp_link_training_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [15:0] lane_state, [31:16] adjust_request,
                                   // [32] align_done, [39:33] zero
  input  logic        in_tuser,    // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [1:0] status, [3:2] pattern, [5:4] swing_level,
                                   // [7:6] emphasis_level, [8] swing_at_max,
                                   // [9] emphasis_at_max, [15:10] lane_set_byte,
                                   // [19:16] drive_code, [20] drive_code_valid, [23:21] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration
  logic [1:0] lane_mode_r;
  logic       drive_table_r;
  logic       pat3_en_r;
  logic       cfg_wr;

  // input stage
  logic        in_v_r;
  logic        in_cmd_r;
  logic [15:0] in_ls_r;
  logic [15:0] in_adj_r;
  logic        in_align_r;
  logic        advance;

  // training state
  dplt_pkg::phase_t phase_r, phase_nxt;
  dplt_pkg::drive_t drv_r, drv_nxt;
  logic [2:0]       rep_cnt_r, rep_cnt_nxt;
  logic [2:0]       try_cnt_r, try_cnt_nxt;
  logic [15:0]      last_adj_r, last_adj_nxt;

  // result stage
  logic        out_v_r;
  logic [23:0] out_data_r, out_data_nxt;

  logic [3:0]       lane_mask;
  logic             cr_ok;
  logic             eq_ok;
  logic             adj_same;
  logic [2:0]       rep_inc;
  logic [2:0]       try_inc;
  logic             rep_fail;
  logic             try_fail;
  logic [1:0]       eq_pat;
  dplt_pkg::drive_t parse_last;
  dplt_pkg::drive_t parse_in;
  dplt_pkg::status_t status_c;
  logic [1:0]       pattern_c;
  logic [4:0]       code_ent;
  logic [5:0]       lane_set;

  function automatic dplt_pkg::drive_t parse_adj(input logic [15:0] adj,
                                                 input logic [3:0]  mask,
                                                 input logic        dt);
    dplt_pkg::drive_t r;
    logic [1:0] s;
    logic [1:0] e;
    logic [1:0] lim;
    s = 2'd0;
    e = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (adj[4*i +: 2] > s) s = adj[4*i +: 2];
        if (adj[4*i+2 +: 2] > e) e = adj[4*i+2 +: 2];
      end
    end
    lim = dplt_pkg::SWING_CLAMP[{dt, e}];
    if (s > lim) s = lim;
    r.swing     = s;
    r.emph      = e;
    r.swing_max = (s == dplt_pkg::SWING_LIMIT[dt]);
    r.emph_max  = (e == dplt_pkg::EMPH_LIMIT[dt]);
    return r;
  endfunction

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_mode_r   <= 2'd2;
      drive_table_r <= 1'b1;
      pat3_en_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case ({cfg_paddr[3:2], 2'b00})
        dplt_pkg::REG_LANE_MODE: lane_mode_r   <= cfg_pwdata[1:0];
        dplt_pkg::REG_DRIVE_TBL: drive_table_r <= cfg_pwdata[0];
        dplt_pkg::REG_PAT3_EN:   pat3_en_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case ({cfg_paddr[3:2], 2'b00})
      dplt_pkg::REG_LANE_MODE: cfg_prdata = {30'd0, lane_mode_r};
      dplt_pkg::REG_DRIVE_TBL: cfg_prdata = {31'd0, drive_table_r};
      dplt_pkg::REG_PAT3_EN:   cfg_prdata = {31'd0, pat3_en_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  assign advance    = in_v_r && (!out_v_r || out_tready);
  assign in_tready  = !in_v_r || advance;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (advance) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r   <= in_tuser;
      in_ls_r    <= in_tdata[15:0];
      in_adj_r   <= in_tdata[31:16];
      in_align_r <= in_tdata[32];
    end
    if (advance) out_data_r <= out_data_nxt;
  end

  // ---------------- lane checks ----------------
  always_comb begin
    unique case (lane_mode_r)
      dplt_pkg::LANE_MODE_1: lane_mask = 4'b0001;
      dplt_pkg::LANE_MODE_2: lane_mask = 4'b0011;
      default:               lane_mask = 4'b1111;
    endcase
  end

  always_comb begin
    cr_ok = 1'b1;
    eq_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (lane_mask[i] && ((in_ls_r[4*i +: 3] & dplt_pkg::CR_BITS) != dplt_pkg::CR_BITS))
        cr_ok = 1'b0;
      if (lane_mask[i] && ((in_ls_r[4*i +: 3] & dplt_pkg::EQ_BITS) != dplt_pkg::EQ_BITS))
        eq_ok = 1'b0;
    end
  end

  assign adj_same   = (in_adj_r == last_adj_r);
  assign rep_inc    = rep_cnt_r + 3'd1;
  assign try_inc    = try_cnt_r + 3'd1;
  assign rep_fail   = adj_same && (rep_inc > dplt_pkg::REPEAT_LIMIT);
  assign try_fail   = try_inc > dplt_pkg::EQ_TRY_LIMIT;
  assign eq_pat     = pat3_en_r ? dplt_pkg::PAT_3 : dplt_pkg::PAT_2;
  assign parse_last = parse_adj(last_adj_r, lane_mask, drive_table_r);
  assign parse_in   = parse_adj(in_adj_r, lane_mask, drive_table_r);

  // ---------------- next phase ----------------
  always_comb begin
    phase_nxt = phase_r;
    if (in_cmd_r == dplt_pkg::CMD_START) begin
      phase_nxt = dplt_pkg::PH_CR;
    end else begin
      unique case (phase_r)
        dplt_pkg::PH_CR: begin
          if (cr_ok) phase_nxt = dplt_pkg::PH_EQ;
          else if (rep_fail || drv_r.swing_max) phase_nxt = dplt_pkg::PH_IDLE;
        end
        dplt_pkg::PH_EQ: begin
          if (!cr_ok || (eq_ok && in_align_r) || try_fail) phase_nxt = dplt_pkg::PH_IDLE;
        end
        default: phase_nxt = dplt_pkg::PH_IDLE;
      endcase
    end
  end

  // ---------------- drive, counters and result ----------------
  always_comb begin
    drv_nxt      = drv_r;
    rep_cnt_nxt  = rep_cnt_r;
    try_cnt_nxt  = try_cnt_r;
    last_adj_nxt = last_adj_r;
    status_c     = dplt_pkg::ST_IDLE;
    pattern_c    = dplt_pkg::PAT_OFF;
    if (in_cmd_r == dplt_pkg::CMD_START) begin
      drv_nxt      = '0;
      rep_cnt_nxt  = 3'd0;
      try_cnt_nxt  = 3'd0;
      last_adj_nxt = 16'd0;
      status_c     = dplt_pkg::ST_PROGRESS;
      pattern_c    = dplt_pkg::PAT_1;
    end else begin
      unique case (phase_r)
        dplt_pkg::PH_CR: begin
          if (cr_ok) begin
            // enter equalization with fresh flags from the last request
            try_cnt_nxt = 3'd0;
            drv_nxt     = parse_last;
            status_c    = dplt_pkg::ST_PROGRESS;
            pattern_c   = eq_pat;
          end else begin
            rep_cnt_nxt  = adj_same ? rep_inc : 3'd0;
            last_adj_nxt = in_adj_r;
            if (rep_fail || drv_r.swing_max) begin
              status_c = dplt_pkg::ST_FAIL;
            end else begin
              drv_nxt.swing     = parse_in.swing;
              drv_nxt.emph      = parse_in.emph;
              drv_nxt.swing_max = drv_r.swing_max | parse_in.swing_max;
              drv_nxt.emph_max  = drv_r.emph_max | parse_in.emph_max;
              status_c          = dplt_pkg::ST_PROGRESS;
              pattern_c         = dplt_pkg::PAT_1;
            end
          end
        end
        dplt_pkg::PH_EQ: begin
          if (!cr_ok) begin
            status_c = dplt_pkg::ST_FAIL;
          end else if (eq_ok && in_align_r) begin
            status_c = dplt_pkg::ST_PASS;
          end else begin
            try_cnt_nxt = try_inc;
            if (try_fail) begin
              status_c = dplt_pkg::ST_FAIL;
            end else begin
              drv_nxt.swing     = parse_in.swing;
              drv_nxt.emph      = parse_in.emph;
              drv_nxt.swing_max = drv_r.swing_max | parse_in.swing_max;
              drv_nxt.emph_max  = drv_r.emph_max | parse_in.emph_max;
              status_c          = dplt_pkg::ST_PROGRESS;
              pattern_c         = eq_pat;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    code_ent = dplt_pkg::DRIVE_CODES[{drive_table_r, drv_nxt.swing, drv_nxt.emph}];
    lane_set = {drv_nxt.emph_max, drv_nxt.emph, drv_nxt.swing_max, drv_nxt.swing};
    out_data_nxt = {3'd0, code_ent[4], code_ent[3:0], lane_set,
                    drv_nxt.emph_max, drv_nxt.swing_max, drv_nxt.emph, drv_nxt.swing,
                    pattern_c, status_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= dplt_pkg::PH_IDLE;
      drv_r      <= '0;
      rep_cnt_r  <= 3'd0;
      try_cnt_r  <= 3'd0;
      last_adj_r <= 16'd0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      drv_r      <= drv_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      try_cnt_r  <= try_cnt_nxt;
      last_adj_r <= last_adj_nxt;
    end
  end

endmodule

// ===== rtl/dplt_checker.sv =====
`include "dp_link_training_sequencer_assert.svh"

module dplt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // result leaves reset empty
  `DPLT_ASSERT_ALWAYS(a_out_empty_after_reset, clk, !rst_n |=> !out_tvalid)

  // hold a stalled result
  `DPLT_ASSERT(a_out_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // training off once passed, failed or idle
  `DPLT_ASSERT(a_pattern_off, clk, rst_n,
    out_tvalid && out_tdata[1:0] != dplt_pkg::ST_PROGRESS |-> out_tdata[3:2] == dplt_pkg::PAT_OFF)

  // lane byte agrees with the drive fields
  `DPLT_ASSERT(a_lane_set, clk, rst_n,
    out_tvalid |-> out_tdata[15:10] == {out_tdata[9], out_tdata[7:6], out_tdata[8], out_tdata[5:4]})

  // invalid drive entry carries a zero code
  `DPLT_ASSERT(a_code_zero, clk, rst_n,
    out_tvalid && !out_tdata[20] |-> out_tdata[19:16] == 4'd0)

endmodule

bind dp_link_training_sequencer dplt_checker u_dplt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
